### design/lqr_pkg.sv
package lqr_pkg;

  localparam int WORD_W = 32;
  localparam int REQ_W  = 2;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_REV  = 2'd3
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

endpackage

### design/lqr_ram.sv
// Word RAM, one write and one registered read port.
module lqr_ram import lqr_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/linear_queue_with_reverse.sv
// Enqueue, dequeue, peek: result on done in the next cycle; one item per cycle while not busy.
// Reverse of n held words: states S_RA, S_RW, S_RB, S_RE, then the result on done (two passes
//   over the slot RAM through a scratch RAM, one word per cycle each), busy high meanwhile.
// Reset (rst, synchronous): queue empty, head and tail at slot 0; RAM contents undefined.
// done results cannot be stalled by the receiver.
module linear_queue_with_reverse import lqr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [REQ_W-1:0]         req_type,
  input  logic signed [WORD_W-1:0] data_value,
  output logic                     done,
  output logic signed [WORD_W-1:0] read_value,
  output logic [ST_W-1:0]          status,
  output logic [OCC_W-1:0]         occupancy,
  output logic                     is_full,
  output logic                     is_empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  // S_FIN shows a result and can take the next item in the same cycle.
  // S_RA..S_RE walk a reverse: copy slots[tail-i] to scratch[i], then scratch[i] to slots[i].
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FIN  = 6'b000010,
    S_RA   = 6'b000100,
    S_RW   = 6'b001000,
    S_RB   = 6'b010000,
    S_RE   = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic             holds, holds_next;
  logic [PTR_W-1:0] idx, idx_next;       // walk index during reverse
  logic [PTR_W-1:0] idx_q, idx_q_next;   // index of the read in flight
  logic [PTR_W-1:0] rev_last, rev_last_next;
  status_t          st_q, st_next;
  logic             rd_ok, rd_ok_next;   // dequeue/peek succeeded: show RAM word

  // slot RAM port controls
  logic              slot_we;
  logic [PTR_W-1:0]  slot_waddr;
  logic [WORD_W-1:0] slot_wdata;
  logic [PTR_W-1:0]  slot_raddr;
  logic [WORD_W-1:0] slot_rdata;

  // scratch RAM used only by reverse
  logic              tmp_we;
  logic [WORD_W-1:0] tmp_rdata;

  logic [CNT_W-1:0]  held;

  lqr_ram #(.DEPTH(QUEUE_DEPTH), .AW(PTR_W)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  lqr_ram #(.DEPTH(QUEUE_DEPTH), .AW(PTR_W)) u_scratch (
    .clk   (clk),
    .we    (tmp_we),
    .waddr (idx_q),
    .wdata (slot_rdata),
    .raddr (idx),
    .rdata (tmp_rdata)
  );

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    holds_next    = holds;
    idx_next      = idx;
    idx_q_next    = idx_q;
    rev_last_next = rev_last;
    st_next       = st_q;
    rd_ok_next    = rd_ok;
    slot_we       = 1'b0;
    slot_waddr    = idx_q;
    slot_wdata    = tmp_rdata;
    slot_raddr    = head;        // head word is fetched on every accept
    tmp_we        = 1'b0;

    unique case (state)
      S_IDLE, S_FIN: begin
        state_next = S_IDLE;
        if (start) begin
          state_next = S_FIN;
          st_next    = ST_OK;
          rd_ok_next = 1'b0;
          unique case (req_t'(req_type))
            REQ_ENQ: begin
              if (holds && (tail == PTR_W'(QUEUE_DEPTH - 1))) begin
                st_next = ST_OVERFLOW;
              end else if (!holds) begin
                head_next  = '0;
                tail_next  = '0;
                holds_next = 1'b1;
                slot_we    = 1'b1;
                slot_waddr = '0;
                slot_wdata = data_value;
              end else begin
                tail_next  = tail + PTR_W'(1);
                slot_we    = 1'b1;
                slot_waddr = tail + PTR_W'(1);
                slot_wdata = data_value;
              end
            end
            REQ_DEQ: begin
              if (!holds) begin
                st_next = ST_EMPTY;
              end else begin
                rd_ok_next = 1'b1;
                if (head == tail) begin
                  // last word leaves: pointers return to slot 0
                  holds_next = 1'b0;
                  head_next  = '0;
                  tail_next  = '0;
                end else begin
                  head_next = head + PTR_W'(1);
                end
              end
            end
            REQ_PEEK: begin
              if (!holds) begin
                st_next = ST_EMPTY;
              end else begin
                rd_ok_next = 1'b1;
              end
            end
            REQ_REV: begin
              // empty queue: nothing to move
              if (holds) begin
                state_next    = S_RA;
                idx_next      = '0;
                rev_last_next = tail - head;
              end
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_RA: begin
        slot_raddr = tail - idx;
        idx_q_next = idx;
        tmp_we     = (idx != '0);   // land the previous read
        if (idx == rev_last) begin
          state_next = S_RW;
        end else begin
          idx_next = idx + PTR_W'(1);
        end
      end
      S_RW: begin
        // last scratch write; gap keeps it clear of the first scratch read
        tmp_we     = 1'b1;
        idx_next   = '0;
        state_next = S_RB;
      end
      S_RB: begin
        idx_q_next = idx;
        slot_we    = (idx != '0);
        if (idx == rev_last) begin
          state_next = S_RE;
        end else begin
          idx_next = idx + PTR_W'(1);
        end
      end
      S_RE: begin
        slot_we    = 1'b1;
        head_next  = '0;
        tail_next  = rev_last;
        state_next = S_FIN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      holds <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      holds <= holds_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    idx_q    <= idx_q_next;
    rev_last <= rev_last_next;
    st_q     <= st_next;
    rd_ok    <= rd_ok_next;
  end

  // Result: flags follow pointers after the request, word from the RAM read at accept.
  assign held       = holds ? (CNT_W'(tail) - CNT_W'(head) + CNT_W'(1)) : '0;
  assign occupancy  = OCC_W'(held);
  assign is_full    = holds && (tail == PTR_W'(QUEUE_DEPTH - 1));
  assign is_empty   = !holds;
  assign status     = st_q;
  assign read_value = rd_ok ? slot_rdata : '0;
  assign done       = (state == S_FIN);
  assign busy       = !((state == S_IDLE) || (state == S_FIN));

endmodule

### sim/linear_queue_with_reverse_tb.sv
module linear_queue_with_reverse_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lqr_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_ITEMS   = 1570;
  // Slowest result is a reverse of a full queue.
  localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;
  // Worst item is a full reverse plus the longest gap; the limit leaves
  // a wide margin over the whole run.
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_REPORTS    = 10;

  // One result, as seen on the done strobe.
  typedef struct packed {
    logic [WORD_W-1:0] rd;
    status_t           st;
    logic [OCC_W-1:0]  occ;
    logic              full;
    logic              empty;
  } queue_result_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [REQ_W-1:0]         req_type;
  logic signed [WORD_W-1:0] data_value;
  logic                     done;
  logic signed [WORD_W-1:0] read_value;
  logic [ST_W-1:0]          status;
  logic [OCC_W-1:0]         occupancy;
  logic                     is_full;
  logic                     is_empty;

  linear_queue_with_reverse #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .data_value (data_value),
    .done       (done),
    .read_value (read_value),
    .status     (status),
    .occupancy  (occupancy),
    .is_full    (is_full),
    .is_empty   (is_empty)
  );

  // Mirror of the queue: slot array, pointers and the not-empty flag.
  logic [WORD_W-1:0] q_slots [DEPTH];
  int unsigned       q_head;
  int unsigned       q_tail;
  bit                q_holds;

  // Results worked out at acceptance, oldest first.
  queue_result_t expected_results[$];

  // Sender pacing.
  int burst_left;
  bit no_idle;
  bit start_high;

  // Bookkeeping.
  int cycle_count;
  int fail_count;
  int results_seen;
  int req_counts [4];
  int overflow_count;
  int empty_err_count;
  int full_count;

  queue_result_t got_res;
  queue_result_t want_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Words held: tail-head+1 while not empty.
  function automatic int unsigned held_words();
    if (!q_holds || q_tail < q_head) return 0;
    return q_tail - q_head + 1;
  endfunction

  // Apply one accepted request to the mirror and queue up its result.
  function automatic void apply_request(req_t r, logic [WORD_W-1:0] w);
    queue_result_t     res;
    logic [WORD_W-1:0] flipped [DEPTH];
    int unsigned       n;
    res    = '0;
    res.st = ST_OK;
    case (r)
      REQ_ENQ: begin
        // Linear queue: overflow once the tail hits the last slot,
        // even if dequeues freed slots at the front.
        if (q_holds && q_tail >= DEPTH - 1) begin
          res.st = ST_OVERFLOW;
        end else if (!q_holds) begin
          q_head     = 0;
          q_tail     = 0;
          q_holds    = 1'b1;
          q_slots[0] = w;
        end else begin
          q_tail          = q_tail + 1;
          q_slots[q_tail] = w;
        end
      end
      REQ_DEQ: begin
        if (!q_holds) begin
          res.st = ST_EMPTY;
        end else begin
          res.rd = q_slots[q_head];
          // Last word out: pointers go back to slot 0.
          if (q_head >= q_tail) begin
            q_holds = 1'b0;
            q_head  = 0;
            q_tail  = 0;
          end else begin
            q_head = q_head + 1;
          end
        end
      end
      REQ_PEEK: begin
        if (!q_holds) res.st = ST_EMPTY;
        else          res.rd = q_slots[q_head];
      end
      default: begin
        // Reverse rebases the held words at slot 0, old tail first.
        n = held_words();
        if (n > 0) begin
          for (int i = 0; i < n; i++) flipped[i] = q_slots[(q_tail - i) % DEPTH];
          for (int i = 0; i < n; i++) q_slots[i] = flipped[i];
          q_head = 0;
          q_tail = n - 1;
        end
      end
    endcase
    res.full  = q_holds && q_tail >= DEPTH - 1;
    res.occ   = OCC_W'(held_words());
    res.empty = !q_holds;
    expected_results.push_back(res);
    req_counts[int'(r)]++;
    if (res.st == ST_OVERFLOW) overflow_count++;
    if (res.st == ST_EMPTY)    empty_err_count++;
    if (res.full)              full_count++;
  endfunction

  // Random word, leaning toward the edges and the all-ones word.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic string describe(queue_result_t v);
    return $sformatf("rd=%h st=%0d occ=%0d full=%0b empty=%0b",
                     v.rd, v.st, v.occ, v.full, v.empty);
  endfunction

  // Send one item. Called at a falling edge; holds start until the block
  // takes the item, then returns at a falling edge. Bursts end with a
  // random gap unless the current stretch runs without idling.
  task automatic send_req(req_t r, logic [WORD_W-1:0] w);
    start      <= 1'b1;
    start_high  = 1'b1;
    req_type   <= r;
    data_value <= w;
    do @(posedge clk); while (busy);
    apply_request(r, w);
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    if (!no_idle && burst_left == 0) begin
      start      <= 1'b0;
      start_high  = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Requests on an empty queue, then a single word in and out.
  task automatic test_empty_requests();
    send_req(REQ_PEEK, $urandom());
    send_req(REQ_DEQ,  $urandom());
    send_req(REQ_REV,  $urandom());
    send_req(REQ_ENQ,  32'h7FFF_FFFF);
    send_req(REQ_PEEK, $urandom());
    send_req(REQ_DEQ,  $urandom());   // last word leaves, queue empties
  endtask

  // Fill all slots, edge words and -1 among them, then overflow.
  task automatic test_fill_and_overflow();
    send_req(REQ_ENQ, 32'h8000_0000);
    send_req(REQ_ENQ, 32'hFFFF_FFFF);
    send_req(REQ_ENQ, 32'h0000_0000);
    send_req(REQ_ENQ, 32'h7FFF_FFFF);
    for (int i = 4; i < DEPTH; i++) send_req(REQ_ENQ, pick_word());
    send_req(REQ_ENQ, 32'hFFFF_FFFF);
  endtask

  // Reverse a full queue, free the head slot (still overflows: linear),
  // reverse with a nonzero head to pull words back to slot 0, then enqueue.
  task automatic test_reverse_cases();
    send_req(REQ_REV,  $urandom());
    send_req(REQ_PEEK, $urandom());
    send_req(REQ_DEQ,  $urandom());
    send_req(REQ_ENQ,  $urandom());
    send_req(REQ_REV,  $urandom());
    send_req(REQ_ENQ,  32'hFFFF_FFFF);
  endtask

  // Segments that lean toward filling, draining or neither, so the queue
  // swings between empty and full many times; reverse and peek sprinkled in.
  task automatic test_random_traffic();
    int   sent;
    int   seg_left;
    int   enq_pct;
    int   roll;
    req_t r;
    sent     = 0;
    seg_left = 0;
    enq_pct  = 50;
    while (sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(12, 60);
        case ($urandom_range(0, 2))
          0:       enq_pct = 75;
          1:       enq_pct = 25;
          default: enq_pct = 50;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 6)                              r = REQ_REV;
      else if (roll < 16)                        r = REQ_PEEK;
      else if ($urandom_range(0, 99) < enq_pct)  r = REQ_ENQ;
      else                                       r = REQ_DEQ;
      // Non-enqueue items still carry random data: it must be ignored.
      send_req(r, (r == REQ_ENQ) ? pick_word() : $urandom());
      seg_left--;
      sent++;
    end
    no_idle = 1'b0;
  endtask

  // Result checker: done is a one-cycle strobe the receiver cannot stall.
  always @(posedge clk) begin
    if (!rst && done) begin
      got_res.rd    = read_value;
      got_res.st    = status_t'(status);
      got_res.occ   = occupancy;
      got_res.full  = is_full;
      got_res.empty = is_empty;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result, none pending: %s", describe(got_res));
      end else begin
        want_res = expected_results.pop_front();
        results_seen++;
        if (got_res !== want_res) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result %0d: expected %s, got %s",
                     results_seen, describe(want_res), describe(got_res));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("linear_queue_with_reverse: mismatch");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    start_high = 1'b0;
    req_type   = REQ_ENQ;
    data_value = '0;
    q_head     = 0;
    q_tail     = 0;
    q_holds    = 1'b0;
    no_idle    = 1'b0;
    burst_left = $urandom_range(1, 24);
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_empty_requests();
    test_fill_and_overflow();
    test_reverse_cases();
    test_random_traffic();

    if (start_high) start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // Anything arriving after this would be an extra result.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      fail_count += expected_results.size();
    end
    $display("covered %0d enqueue, %0d dequeue, %0d peek, %0d reverse items; %0d results checked",
             req_counts[0], req_counts[1], req_counts[2], req_counts[3], results_seen);
    $display("overflows %0d, empty-queue errors %0d, full-queue results %0d, failures %0d",
             overflow_count, empty_err_count, full_count, fail_count);
    if (fail_count == 0) begin
      $display("linear_queue_with_reverse: match");
    end else begin
      $display("linear_queue_with_reverse: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
design/lqr_pkg.sv
design/lqr_ram.sv
design/linear_queue_with_reverse.sv
sim/linear_queue_with_reverse_tb.sv
